### sv/rbcm_pkg.sv
// ----------------------------------------------------------------------------
// rbcm_pkg: shared types and constants for the LED panel scan driver
// Holds the request and result item layouts, the configuration register
// set, the controller states and the field-width helper for the frame store.
// ----------------------------------------------------------------------------
package rbcm_pkg;

  // Default panel geometry.
  localparam int WIDTH_DEF      = 32;
  localparam int ROW_PAIRS_DEF  = 16;
  localparam int COLOR_BITS_DEF = 8;

  // Configuration reset values and register indexes.
  localparam logic        DBUF_RST      = 1'b1;
  localparam logic [15:0] FRAME_GAP_RST = 16'd13125;
  localparam logic        CFG_IDX_DBUF  = 1'b0;
  localparam logic        CFG_IDX_GAP   = 1'b1;
  localparam int          CFG_ADDR_W    = 3;

  // Request types.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_SWAP  = 2'd2;

  // Result kinds.
  localparam logic [1:0] STEP_SHIFT  = 2'd0;
  localparam logic [1:0] STEP_LATCH  = 2'd1;
  localparam logic [1:0] STEP_TIMING = 2'd2;

  // Half-word keep masks for the packed two-scan colour word.
  localparam logic [5:0] UPPER_KEEP_MASK = 6'b111000;
  localparam logic [5:0] LOWER_KEEP_MASK = 6'b000111;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] pixel_x;
    logic [6:0] pixel_y;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       copy_on_swap;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  step_kind;
    logic [5:0]  color_bits;
    logic [3:0]  row_address;
    logic        blank;
    logic [15:0] next_delay;
    logic        swap_done;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        double_buffered;
    logic [15:0] frame_gap_delay;
  } cfg_t;

  // Status of the result queue as seen by the controller.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_SHIFT,
    ST_LATCH,
    ST_STEP,
    ST_COPY
  } ctrl_state_t;

  // Address field width for n values, never below one bit.
  function automatic int fld_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

### sv/rbcm_if.sv
// ----------------------------------------------------------------------------
// rbcm_if: valid/ready channels of the scan driver
// One channel carries request items into the block, the other result items
// out of it.
// ----------------------------------------------------------------------------
interface rbcm_in_if;
  import rbcm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbcm_out_if;
  import rbcm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/rbcm_frame_mem.sv
// ----------------------------------------------------------------------------
// rbcm_frame_mem: bit-plane frame store
// Single-port-read, single-port-write synchronous memory with registered
// read data. A read of the address being written returns the old word.
// ----------------------------------------------------------------------------
module rbcm_frame_mem #(
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [5:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [5:0]        wr_data
);
  localparam int DEPTH = 2 ** ADDR_W;

  logic [5:0] mem [DEPTH];
  logic [5:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

### sv/rbcm_out_fifo.sv
// ----------------------------------------------------------------------------
// rbcm_out_fifo: two-entry result queue
// Decouples the frame store read stream from stalls on the result channel,
// so that one shift word a cycle can leave while the sink keeps pace.
// ----------------------------------------------------------------------------
module rbcm_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rbcm_pkg::out_item_t  push_item,
  output rbcm_pkg::fifo_stat_t stat,
  rbcm_out_if.source           out_chan
);
  import rbcm_pkg::*;

  out_item_t  ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign pop = out_chan.valid && out_chan.ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  assign out_chan.valid = (count_r != 2'd0);
  assign out_chan.data  = ent_r[rd_ptr_r];
  assign stat.count     = count_r;
  assign stat.pop       = pop;
endmodule

### sv/rbcm_cfg.sv
// ----------------------------------------------------------------------------
// rbcm_cfg: configuration register file
// APB-style slave holding the buffering mode and the frame gap delay.
// Registers are decoded by word index only; pready is always high.
// ----------------------------------------------------------------------------
module rbcm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbcm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output rbcm_pkg::cfg_t                  cfg
);
  import rbcm_pkg::*;

  logic        dbuf_r;
  logic        dbuf_nxt;
  logic [15:0] gap_r;
  logic [15:0] gap_nxt;
  logic        wr_strobe;
  logic        reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign wr_strobe = psel && penable && pwrite && pready;

  // Register write decode.
  always_comb begin
    dbuf_nxt = dbuf_r;
    gap_nxt  = gap_r;
    if (wr_strobe) begin
      unique case (reg_idx)
        CFG_IDX_DBUF: dbuf_nxt = pwdata[0];
        CFG_IDX_GAP:  gap_nxt  = pwdata[15:0];
        default:      dbuf_nxt = dbuf_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbuf_r <= DBUF_RST;
      gap_r  <= FRAME_GAP_RST;
    end else begin
      dbuf_r <= dbuf_nxt;
      gap_r  <= gap_nxt;
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_idx)
      CFG_IDX_DBUF: prdata = {31'd0, dbuf_r};
      CFG_IDX_GAP:  prdata = {16'd0, gap_r};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg.double_buffered = dbuf_r;
  assign cfg.frame_gap_delay = gap_r;
endmodule

### sv/rbcm_ctrl.sv
// ----------------------------------------------------------------------------
// rbcm_ctrl: scan sequencer and frame store access control
// Clears the frame store after reset, performs the per-plane
// read-modify-write of pixel writes, streams bit-plane rows to the result
// queue, steps the frame-end phases and runs the copy sweep on a swap with copy.
// ----------------------------------------------------------------------------
module rbcm_ctrl #(
  parameter int WIDTH      = rbcm_pkg::WIDTH_DEF,
  parameter int ROW_PAIRS  = rbcm_pkg::ROW_PAIRS_DEF,
  parameter int COLOR_BITS = rbcm_pkg::COLOR_BITS_DEF,
  parameter int ADDR_W     = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbcm_pkg::cfg_t       cfg,
  rbcm_in_if.sink              in_chan,
  output logic                 mem_rd_en,
  output logic [ADDR_W-1:0]    mem_rd_addr,
  input  logic [5:0]           mem_rd_data,
  output logic                 mem_wr_en,
  output logic [ADDR_W-1:0]    mem_wr_addr,
  output logic [5:0]           mem_wr_data,
  output logic                 push,
  output rbcm_pkg::out_item_t  push_item,
  input  rbcm_pkg::fifo_stat_t fifo_stat
);
  import rbcm_pkg::*;

  localparam int XW    = fld_w(WIDTH);
  localparam int RW    = fld_w(ROW_PAIRS);
  localparam int PW    = fld_w(COLOR_BITS);
  localparam int PLW   = $clog2(COLOR_BITS + 1);
  localparam int PHW   = $clog2(ROW_PAIRS + 2);
  localparam int CW    = ADDR_W + 1;
  localparam int DEPTH = 2 ** ADDR_W;
  localparam int HALF  = 2 ** (ADDR_W - 1);

  ctrl_state_t       state_r;
  ctrl_state_t       state_nxt;
  in_item_t          item_r;
  in_item_t          item_nxt;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic              front_r;
  logic              front_nxt;
  logic [PLW-1:0]    plane_r;
  logic [PLW-1:0]    plane_nxt;
  logic [PHW-1:0]    phase_r;
  logic [PHW-1:0]    phase_nxt;
  logic [15:0]       delay_r;
  logic [15:0]       delay_nxt;
  logic              swap_pend_r;
  logic              swap_pend_nxt;
  logic              copy_pend_r;
  logic              copy_pend_nxt;
  logic              rd_v_r;
  logic              rd_v_nxt;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [ADDR_W-1:0] wr_addr_nxt;
  logic [PW-1:0]     rd_plane_r;
  logic [PW-1:0]     rd_plane_nxt;

  logic              in_ready;
  logic              accept;
  logic              on_panel;
  logic              tick_shift;
  logic              can_push;
  logic              stream_ok;
  logic              latch_push;
  logic              step_push;
  logic              go_copy;
  logic [RW-1:0]     row_sel;
  logic              pix_buf;
  logic              pix_upper;
  logic [6:0]        pix_y_low;
  logic [RW-1:0]     pix_row;
  logic [2:0]        pix_rgb;
  logic [15:0]       delay_dbl;
  logic [2:0]        occ_after;

  // Handshake and item classification.
  assign in_ready      = (state_r == ST_IDLE);
  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;
  assign on_panel      = (in_chan.data.pixel_x < 7'(WIDTH)) &&
                         (in_chan.data.pixel_y < 7'(2 * ROW_PAIRS));
  assign tick_shift    = (plane_r < PLW'(COLOR_BITS));

  // Queue space: a read issued now lands in the next cycle and needs a slot.
  assign occ_after  = {1'b0, fifo_stat.count} + {2'd0, rd_v_r} - {2'd0, fifo_stat.pop};
  assign stream_ok  = (occ_after <= 3'd1);
  assign can_push   = (fifo_stat.count != 2'd2) || fifo_stat.pop;
  assign latch_push = (state_r == ST_LATCH) && !rd_v_r && can_push;
  assign step_push  = (state_r == ST_STEP) && can_push;
  assign go_copy    = step_push && (phase_r == PHW'(ROW_PAIRS)) && swap_pend_r && copy_pend_r;

  // Row pair being scanned, and the pixel-write target.
  assign row_sel   = (phase_r < PHW'(ROW_PAIRS)) ? phase_r[RW-1:0] : '0;
  assign pix_buf   = cfg.double_buffered ? ~front_r : front_r;
  assign pix_upper = (item_r.pixel_y < 7'(ROW_PAIRS));
  assign pix_y_low = item_r.pixel_y - 7'(ROW_PAIRS);
  assign pix_row   = pix_upper ? item_r.pixel_y[RW-1:0] : pix_y_low[RW-1:0];
  assign pix_rgb   = {item_r.red_level[rd_plane_r], item_r.green_level[rd_plane_r],
                      item_r.blue_level[rd_plane_r]};
  assign delay_dbl = {delay_r[14:0], 1'b0};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == CW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (in_chan.data.req_type == REQ_TICK) begin
            state_nxt = tick_shift ? ST_SHIFT : ST_STEP;
          end else if (in_chan.data.req_type == REQ_PIXEL && on_panel) begin
            state_nxt = ST_PIX;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PIX: begin
        if (cnt_r == CW'(COLOR_BITS)) state_nxt = ST_IDLE;
      end
      ST_SHIFT: begin
        if (cnt_r == CW'(WIDTH)) state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        if (latch_push) state_nxt = ST_IDLE;
      end
      ST_STEP: begin
        if (step_push) state_nxt = go_copy ? ST_COPY : ST_IDLE;
      end
      ST_COPY: begin
        if (cnt_r == CW'(HALF)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory and queue control.
  always_comb begin
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    front_nxt     = front_r;
    plane_nxt     = plane_r;
    phase_nxt     = phase_r;
    delay_nxt     = delay_r;
    swap_pend_nxt = swap_pend_r;
    copy_pend_nxt = copy_pend_r;
    rd_v_nxt      = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    rd_plane_nxt  = rd_plane_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = wr_addr_r;
    mem_wr_data   = mem_rd_data;
    push          = 1'b0;
    push_item     = '0;

    unique case (state_r)
      // Clearing pass: one zero word a cycle over the whole store.
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cnt_r[ADDR_W-1:0];
        mem_wr_data = 6'd0;
        cnt_nxt     = cnt_r + CW'(1);
      end

      // Take a request; swap requests only set the pending flags.
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          item_nxt = in_chan.data;
          if (in_chan.data.req_type == REQ_SWAP && cfg.double_buffered) begin
            swap_pend_nxt = 1'b1;
            copy_pend_nxt = in_chan.data.copy_on_swap;
          end
        end
      end

      // Pixel write: read plane i while writing back plane i-1.
      ST_PIX: begin
        if (cnt_r < CW'(COLOR_BITS)) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = {pix_buf, pix_row, cnt_r[PW-1:0], item_r.pixel_x[XW-1:0]};
          wr_addr_nxt  = mem_rd_addr;
          rd_plane_nxt = cnt_r[PW-1:0];
          rd_v_nxt     = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
        end
        if (rd_v_r) begin
          mem_wr_en = 1'b1;
          if (pix_upper) begin
            mem_wr_data = (mem_rd_data & UPPER_KEEP_MASK) | {3'd0, pix_rgb};
          end else begin
            mem_wr_data = (mem_rd_data & LOWER_KEEP_MASK) | {pix_rgb, 3'd0};
          end
        end
      end

      // Stream one bit-plane row of the front buffer as shift words, then the latch step.
      ST_SHIFT, ST_LATCH: begin
        if (state_r == ST_SHIFT && cnt_r < CW'(WIDTH) && stream_ok) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {front_r, row_sel, plane_r[PW-1:0], cnt_r[XW-1:0]};
          rd_v_nxt    = 1'b1;
          cnt_nxt     = cnt_r + CW'(1);
        end
        if (rd_v_r) begin
          push                 = 1'b1;
          push_item.step_kind  = STEP_SHIFT;
          push_item.color_bits = mem_rd_data;
          push_item.blank      = 1'b1;
        end else if (latch_push) begin
          push                  = 1'b1;
          push_item.step_kind   = STEP_LATCH;
          push_item.row_address = 4'(row_sel);
          push_item.next_delay  = delay_dbl;
          push_item.last        = 1'b1;
          delay_nxt             = delay_dbl;
          plane_nxt             = plane_r + PLW'(1);
        end
      end

      // Row step and frame-end phases.
      ST_STEP: begin
        if (step_push) begin
          push                = 1'b1;
          push_item.step_kind = STEP_TIMING;
          push_item.last      = 1'b1;
          priority if (phase_r == PHW'(ROW_PAIRS - 1)) begin
            phase_nxt = PHW'(ROW_PAIRS);
            delay_nxt = 16'd1;
          end else if (phase_r == PHW'(ROW_PAIRS)) begin
            phase_nxt       = PHW'(ROW_PAIRS + 1);
            delay_nxt       = cfg.frame_gap_delay;
            push_item.blank = 1'b1;
            if (swap_pend_r) begin
              front_nxt           = ~front_r;
              swap_pend_nxt       = 1'b0;
              copy_pend_nxt       = 1'b0;
              push_item.swap_done = 1'b1;
            end
          end else if (phase_r == PHW'(ROW_PAIRS + 1)) begin
            phase_nxt       = '0;
            plane_nxt       = '0;
            delay_nxt       = 16'd1;
            push_item.blank = 1'b1;
          end else begin
            phase_nxt = (phase_r < PHW'(ROW_PAIRS - 1)) ? phase_r + PHW'(1) : '0;
            plane_nxt = '0;
            delay_nxt = 16'd1;
          end
          push_item.next_delay = delay_nxt;
        end
      end

      // Copy the new front buffer into the back buffer, one word a cycle.
      ST_COPY: begin
        if (cnt_r < CW'(HALF)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = {front_r, cnt_r[ADDR_W-2:0]};
          wr_addr_nxt = {~front_r, cnt_r[ADDR_W-2:0]};
          rd_v_nxt    = 1'b1;
          cnt_nxt     = cnt_r + CW'(1);
        end
        if (rd_v_r) begin
          mem_wr_en = 1'b1;
        end
      end

      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      front_r     <= 1'b0;
      plane_r     <= '0;
      phase_r     <= '0;
      delay_r     <= 16'd1;
      swap_pend_r <= 1'b0;
      copy_pend_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      front_r     <= front_nxt;
      plane_r     <= plane_nxt;
      phase_r     <= phase_nxt;
      delay_r     <= delay_nxt;
      swap_pend_r <= swap_pend_nxt;
      copy_pend_r <= copy_pend_nxt;
      rd_v_r      <= rd_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    wr_addr_r  <= wr_addr_nxt;
    rd_plane_r <= rd_plane_nxt;
  end

  // The queue is never pushed when full and not draining.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fifo_stat.count != 2'd2 || fifo_stat.pop))
    else $error("result pushed into a full queue");

  // A read-modify-write never reads the word being written back.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
    else $error("frame store read and write hit the same word");

  // Frame-end phases are only reached with every plane shown.
  a_phase_plane: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r >= PHW'(ROW_PAIRS)) |-> (plane_r == PLW'(COLOR_BITS)))
    else $error("frame-end phase with planes still to show");

  // Latch waits for the row stream to drain before leaving.
  a_latch_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LATCH) |=> !rd_v_r)
    else $error("read still in flight after latch");
endmodule

### sv/rgb_matrix_bcm_scan_driver_top.sv
// ----------------------------------------------------------------------------
// rgb_matrix_bcm_scan_driver_top: two-scan LED panel driver
// Bit-plane frame store with pixel writes, binary code modulation row scan
// and double-buffered frame swap.
//
//   Channel   Direction  Protocol       Carries
//   in_chan   sink       valid/ready    tick, pixel write or swap request
//   out_chan  source     valid/ready    shift word, latch or timing step
//   psel...   slave      APB-style      double_buffered, frame_gap_delay
//
// After reset the frame store, 2**ADDR_W words (8192 at the default geometry),
// is cleared before the first request is taken.
// A plane tick streams WIDTH shift words and a latch step, fed by the single
// frame store read port at one shift word a cycle while results do not stall;
// other ticks push one timing step. A pixel write does a read-modify-write of
// each plane; a swap with copy adds a copy sweep of 2**(ADDR_W-1) words.
// Result stalls back-pressure the row stream through a two-entry queue.
// ----------------------------------------------------------------------------
module rgb_matrix_bcm_scan_driver_top #(
  parameter int WIDTH      = rbcm_pkg::WIDTH_DEF,
  parameter int ROW_PAIRS  = rbcm_pkg::ROW_PAIRS_DEF,
  parameter int COLOR_BITS = rbcm_pkg::COLOR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rbcm_in_if.sink                         in_chan,
  rbcm_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbcm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rbcm_pkg::*;

  localparam int ADDR_W = 1 + fld_w(ROW_PAIRS) + fld_w(COLOR_BITS) + fld_w(WIDTH);

  cfg_t              cfg;
  fifo_stat_t        fifo_stat;
  out_item_t         push_item;
  logic              push;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [5:0]        mem_rd_data;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [5:0]        mem_wr_data;

  // Configuration registers.
  rbcm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame store.
  rbcm_frame_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Sequencer.
  rbcm_ctrl #(
    .WIDTH      (WIDTH),
    .ROW_PAIRS  (ROW_PAIRS),
    .COLOR_BITS (COLOR_BITS),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_chan     (in_chan),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .push        (push),
    .push_item   (push_item),
    .fifo_stat   (fifo_stat)
  );

  // Result queue.
  rbcm_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .stat      (fifo_stat),
    .out_chan  (out_chan)
  );
endmodule

### bench/scan_checker.sv
// ----------------------------------------------------------------------------
// scan_checker: result predictor and comparator for the LED panel scan driver
// Watches the request channel, the result channel and the configuration
// port, keeps its own copy of the bit-plane frame store and scan state, and
// compares every accepted result, field by field, with the oldest predicted
// step. Failures and progress counts are handed to the testbench top.
// ----------------------------------------------------------------------------
module scan_checker #(
  parameter int WIDTH      = rbcm_pkg::WIDTH_DEF,
  parameter int ROW_PAIRS  = rbcm_pkg::ROW_PAIRS_DEF,
  parameter int COLOR_BITS = rbcm_pkg::COLOR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rbcm_in_if                              req_mon,
  rbcm_out_if                             res_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbcm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  input  logic [31:0]                     prdata,
  input  logic                            pready,
  output int                              fail_count,
  output int                              pending_steps,
  output int                              requests_seen,
  output int                              results_checked,
  output int                              frame_ends,
  output int                              swaps_applied
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbcm_pkg::*;

  localparam int ROW_WORDS = WIDTH * COLOR_BITS;
  localparam logic [CFG_ADDR_W-1:0] DBUF_ADDR = CFG_ADDR_W'({CFG_IDX_DBUF, 2'b00});
  localparam logic [CFG_ADDR_W-1:0] GAP_ADDR  = CFG_ADDR_W'({CFG_IDX_GAP, 2'b00});

  // Shadow of the two frame buffers and of the scan controller.
  logic [5:0]  plane_store [2][ROW_PAIRS][ROW_WORDS];
  logic        front_sel;
  int          plane_idx;
  int          scan_row;
  logic [15:0] row_delay;
  logic        swap_armed;
  logic        copy_armed;
  cfg_t        regs;
  out_item_t   expected_steps[$];

  task automatic clear_model();
    for (int b = 0; b < 2; b++) begin
      for (int r = 0; r < ROW_PAIRS; r++) begin
        for (int w = 0; w < ROW_WORDS; w++) begin
          plane_store[b][r][w] = '0;
        end
      end
    end
    front_sel  = 1'b0;
    plane_idx  = 0;
    scan_row   = 0;
    row_delay  = 16'd1;
    swap_armed = 1'b0;
    copy_armed = 1'b0;
    regs.double_buffered = DBUF_RST;
    regs.frame_gap_delay = FRAME_GAP_RST;
    expected_steps.delete();
  endtask

  task automatic queue_step(input logic [1:0] kind, input logic [5:0] bits,
                            input logic [3:0] row, input logic blank,
                            input logic [15:0] delay, input logic swapped,
                            input logic last);
    out_item_t s;
    s.step_kind   = kind;
    s.color_bits  = bits;
    s.row_address = row;
    s.blank       = blank;
    s.next_delay  = delay;
    s.swap_done   = swapped;
    s.last        = last;
    expected_steps.push_back(s);
  endtask

  // Read-modify-write of one packed word per bit plane.
  task automatic store_pixel(input in_item_t req);
    logic       buf_sel;
    logic       upper;
    int         row;
    logic [2:0] rgb;
    int         idx;
    if (req.pixel_x >= WIDTH || req.pixel_y >= 2 * ROW_PAIRS) return;
    buf_sel = regs.double_buffered ? ~front_sel : front_sel;
    upper   = req.pixel_y < ROW_PAIRS;
    row     = upper ? int'(req.pixel_y) : int'(req.pixel_y) - ROW_PAIRS;
    for (int p = 0; p < COLOR_BITS; p++) begin
      rgb = {req.red_level[p], req.green_level[p], req.blue_level[p]};
      idx = p * WIDTH + int'(req.pixel_x);
      if (upper) begin
        plane_store[buf_sel][row][idx] =
          (plane_store[buf_sel][row][idx] & UPPER_KEEP_MASK) | {3'b000, rgb};
      end else begin
        plane_store[buf_sel][row][idx] =
          (plane_store[buf_sel][row][idx] & LOWER_KEEP_MASK) | {rgb, 3'b000};
      end
    end
  endtask

  // One timer tick: a bit plane of the current row pair, or a timing step.
  task automatic advance_scan();
    int   row;
    logic swapped;
    if (plane_idx < COLOR_BITS) begin
      row       = (scan_row < ROW_PAIRS) ? scan_row : 0;
      row_delay = row_delay << 1;
      for (int k = 0; k < WIDTH; k++) begin
        queue_step(STEP_SHIFT, plane_store[front_sel][row][plane_idx * WIDTH + k],
                   4'd0, 1'b1, 16'd0, 1'b0, 1'b0);
      end
      queue_step(STEP_LATCH, 6'd0, 4'(row), 1'b0, row_delay, 1'b0, 1'b1);
      plane_idx++;
    end else if (scan_row == ROW_PAIRS - 1) begin
      scan_row  = ROW_PAIRS;
      row_delay = 16'd1;
      queue_step(STEP_TIMING, 6'd0, 4'd0, 1'b0, row_delay, 1'b0, 1'b1);
    end else if (scan_row == ROW_PAIRS) begin
      // Frame-end blanking: long gap and any pending buffer swap.
      scan_row  = ROW_PAIRS + 1;
      row_delay = regs.frame_gap_delay;
      swapped   = 1'b0;
      if (swap_armed) begin
        front_sel = ~front_sel;
        if (copy_armed) begin
          for (int r = 0; r < ROW_PAIRS; r++) begin
            for (int w = 0; w < ROW_WORDS; w++) begin
              plane_store[~front_sel][r][w] = plane_store[front_sel][r][w];
            end
          end
        end
        copy_armed = 1'b0;
        swap_armed = 1'b0;
        swapped    = 1'b1;
        swaps_applied++;
      end
      frame_ends++;
      queue_step(STEP_TIMING, 6'd0, 4'd0, 1'b1, row_delay, swapped, 1'b1);
    end else if (scan_row == ROW_PAIRS + 1) begin
      scan_row  = 0;
      plane_idx = 0;
      row_delay = 16'd1;
      queue_step(STEP_TIMING, 6'd0, 4'd0, 1'b1, row_delay, 1'b0, 1'b1);
    end else begin
      scan_row  = scan_row + 1;
      plane_idx = 0;
      row_delay = 16'd1;
      queue_step(STEP_TIMING, 6'd0, 4'd0, 1'b0, row_delay, 1'b0, 1'b1);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // All channels are sampled at the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_model();
      fail_count      = 0;
      requests_seen   = 0;
      results_checked = 0;
      frame_ends      = 0;
      swaps_applied   = 0;
    end else begin
      // Register writes and read-back.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == DBUF_ADDR) regs.double_buffered = pwdata[0];
          else if (paddr == GAP_ADDR) regs.frame_gap_delay = pwdata[15:0];
        end else if (paddr == DBUF_ADDR) begin
          check_field("prdata", {31'd0, regs.double_buffered}, prdata);
        end else if (paddr == GAP_ADDR) begin
          check_field("prdata", {16'd0, regs.frame_gap_delay}, prdata);
        end
      end

      // Results against the oldest prediction.
      if (res_mon.valid && res_mon.ready) begin
        if (expected_steps.size() == 0) begin
          $error("result with no prediction waiting: kind %0d", res_mon.data.step_kind);
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          check_field("step_kind", want.step_kind, res_mon.data.step_kind);
          check_field("color_bits", want.color_bits, res_mon.data.color_bits);
          check_field("row_address", want.row_address, res_mon.data.row_address);
          check_field("blank", want.blank, res_mon.data.blank);
          check_field("next_delay", want.next_delay, res_mon.data.next_delay);
          check_field("swap_done", want.swap_done, res_mon.data.swap_done);
          check_field("last", want.last, res_mon.data.last);
          results_checked++;
        end
      end

      // Accepted requests update the shadow state.
      if (req_mon.valid && req_mon.ready) begin
        requests_seen++;
        case (req_mon.data.req_type)
          REQ_TICK: begin
            advance_scan();
          end
          REQ_PIXEL: begin
            store_pixel(req_mon.data);
          end
          REQ_SWAP: begin
            if (regs.double_buffered) begin
              swap_armed = 1'b1;
              copy_armed = req_mon.data.copy_on_swap;
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending_steps = expected_steps.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the LED panel scan driver
// Drives pixel writes, timer ticks and swap requests through the request
// channel under varying idle and stall patterns, reprograms the buffering
// mode and frame gap between phases, and reports what the checker found.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbcm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] DBUF_ADDR = CFG_ADDR_W'({CFG_IDX_DBUF, 2'b00});
  localparam logic [CFG_ADDR_W-1:0] GAP_ADDR  = CFG_ADDR_W'({CFG_IDX_GAP, 2'b00});
  // Covers the copy sweep that may follow the last result.
  localparam int SETTLE_CYCLES = 4500;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 33;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold     = 0;

  int fail_count;
  int pending_steps;
  int requests_seen;
  int results_checked;
  int frame_ends;
  int swaps_applied;

  rbcm_in_if  in_chan ();
  rbcm_out_if out_chan ();

  rgb_matrix_bcm_scan_driver_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scan_checker u_scan_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (in_chan),
    .res_mon        (out_chan),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending_steps  (pending_steps),
    .requests_seen  (requests_seen),
    .results_checked(results_checked),
    .frame_ends     (frame_ends),
    .swaps_applied  (swaps_applied)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #25000000;
    $display("Mismatches found");
    $finish;
  end

  // Result receiver: random stalls, or a long hold-off when one is asked for.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_chan.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic in_item_t make_request(input logic [1:0] kind, input logic [6:0] x,
                                            input logic [6:0] y, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic copy);
    in_item_t it;
    it.req_type     = kind;
    it.pixel_x      = x;
    it.pixel_y      = y;
    it.red_level    = r;
    it.green_level  = g;
    it.blue_level   = b;
    it.copy_on_swap = copy;
    return it;
  endfunction

  // Mostly ticks, with pixel writes, swaps and some noise mixed in.
  function automatic in_item_t random_request();
    in_item_t it;
    int       pick;
    it = make_request(REQ_TICK, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      it.req_type = REQ_TICK;
    end else if (pick < 92) begin
      it.req_type = REQ_PIXEL;
      it.pixel_x  = 7'($urandom_range(0, WIDTH_DEF - 1));
      it.pixel_y  = 7'($urandom_range(0, 2 * ROW_PAIRS_DEF - 1));
    end else if (pick < 94) begin
      it.req_type = REQ_PIXEL;
    end else if (pick < 97) begin
      it.req_type = REQ_SWAP;
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  // Offer one request, with random idle cycles first; returns after acceptance.
  task automatic push_request(input in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // One configuration access: setup cycle, access cycle, then an idle cycle.
  task automatic cfg_access(input logic write_en, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Write a register with junk in the unused bits, then read it back.
  task automatic program_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value,
                             input logic [31:0] mask);
    cfg_access(1'b1, addr, (value & mask) | ($urandom & ~mask));
    cfg_access(1'b0, addr, $urandom);
  endtask

  task automatic wait_drained();
    while (pending_steps != 0) @(negedge clk);
  endtask

  // A random phase offers a fixed number of requests.
  task automatic run_phase(input int tx_pct, input int rx_pct, input logic dbuf,
                           input logic [15:0] gap, input logic squeeze);
    int n;
    n = 0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    program_reg(DBUF_ADDR, {31'd0, dbuf}, 32'h0000_0001);
    program_reg(GAP_ADDR, {16'd0, gap}, 32'h0000_FFFF);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (n < PHASE_ITEMS) begin
      if (squeeze && n == 4) rx_hold = HOLD_CYCLES;
      if (n == 20) begin
        // Let the block run dry before the next request.
        in_chan.valid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
      push_request(random_request());
      n++;
    end
    in_chan.valid <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    in_item_t directed[$];
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single buffering so that writes show on the next planes.
    tx_idle_pct = 21;
    rx_idle_pct = 68;
    program_reg(DBUF_ADDR, 32'd0, 32'h0000_0001);
    program_reg(GAP_ADDR, 32'd65535, 32'h0000_FFFF);

    // Some corners of both panel halves, off-panel writes, unused type, ignored swap.
    directed.push_back(make_request(REQ_PIXEL, 7'd0, 7'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    directed.push_back(make_request(REQ_PIXEL, 7'd31, 7'd0, 8'hAA, 8'h55, 8'h0F, 1'b1));
    directed.push_back(make_request(REQ_PIXEL, 7'd31, 7'd16, 8'hFF, 8'h00, 8'h80, 1'b0));
    directed.push_back(make_request(REQ_PIXEL, 7'd0, 7'd16, 8'h01, 8'hFE, 8'h7F, 1'b1));
    directed.push_back(make_request(REQ_PIXEL, 7'd7, 7'd15, 8'h3C, 8'hC3, 8'h99, 1'b0));
    directed.push_back(make_request(REQ_PIXEL, 7'd0, 7'd31, 8'h00, 8'h00, 8'h00, 1'b0));
    directed.push_back(make_request(REQ_PIXEL, 7'd32, 7'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    directed.push_back(make_request(REQ_PIXEL, 7'd0, 7'd32, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    directed.push_back(make_request(REQ_PIXEL, 7'd127, 7'd127, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    directed.push_back(make_request(REQ_UNUSED, 7'd127, 7'd127, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    directed.push_back(make_request(REQ_SWAP, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 1'b1));
    directed.push_back(make_request(REQ_TICK, 7'd127, 7'd127, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    for (int i = 0; i < COLOR_BITS_DEF; i++) begin
      directed.push_back(make_request(REQ_TICK, 7'd0, 7'd0, 8'h00, 8'h00, 8'h00, 1'b0));
    end
    foreach (directed[i]) push_request(directed[i]);
    in_chan.valid <= 1'b0;

    run_phase(21, 68, 1'b1, 16'd0, 1'b0);
    run_phase(68, 21, 1'b0, 16'($urandom_range(1, 65534)), 1'b0);
    run_phase(0, 0, 1'b1, 16'd65535, 1'b1);

    // Drain, then give stray results time to show up.
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Run covered %0d requests and %0d checked results,", requests_seen,
             results_checked);
    $display("including %0d frame ends and %0d buffer swaps.", frame_ends, swaps_applied);
    if (fail_count == 0 && pending_steps == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
